// ===== rtl/core/mmi96_pkg.sv =====
package mmi96_pkg;

  // Field widths of the ports.
  localparam int unsigned LOW_BITS  = 64;
  localparam int unsigned HIGH_BITS = 32;
  localparam int unsigned MOD_BITS  = LOW_BITS + HIGH_BITS;
  localparam int unsigned WIDE_BITS = 128;
  localparam int unsigned ACC_BITS  = 192;
  localparam int unsigned LIMB_BITS = 32;

  // Default REDC word width.
  localparam int unsigned WORD_BITS_DEF = 64;

  // Signed power-of-two counter width; covers -64 up to a few hundred.
  localparam int unsigned T_BITS = 10;

  // Configuration register indexes.
  localparam logic [1:0] REG_MOD_LOW  = 2'd0;
  localparam logic [1:0] REG_MOD_HIGH = 2'd1;
  localparam logic [1:0] REG_NEG_INV  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [63:0] MOD_LOW_RST  = 64'd3;
  localparam logic [31:0] MOD_HIGH_RST = 32'd0;
  localparam logic [63:0] NEG_INV_RST  = 64'h5555_5555_5555_5555;

  // Datapath operation codes.
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_CLR   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_ACC   = 4'd4;
  localparam logic [3:0] OP_KSET  = 4'd5;
  localparam logic [3:0] OP_RDONE = 4'd6;
  localparam logic [3:0] OP_INIT  = 4'd7;
  localparam logic [3:0] OP_SHA   = 4'd8;
  localparam logic [3:0] OP_SHB   = 4'd9;
  localparam logic [3:0] OP_SUBA  = 4'd10;
  localparam logic [3:0] OP_SUBB  = 4'd11;
  localparam logic [3:0] OP_DBL   = 4'd12;
  localparam logic [3:0] OP_OK    = 4'd13;
  localparam logic [3:0] OP_FAIL  = 4'd14;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [3:0] op;
    logic       kph;    // REDC quotient phase: multiply by the negated inverse
    logic       use_u;  // REDC works on the cofactor rather than on a
    logic       s_var;  // REDC shift taken from the counter rather than the word width
    logic       xi;     // limb of the first operand
    logic [1:0] yj;     // limb of the second operand
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_odd;
    logic a_zero;
    logic a_lt_m;
    logic a_one;
    logic a_eq_b;
    logic a_lt_b;
    logic a_odd;
    logic b_odd;
    logic t_neg;
    logic t_pos;
    logic t_ge_w;
  } sts_t;

endpackage

// ===== rtl/core/montgomery_modular_inverse_96.sv =====
// Montgomery inverse modulo an odd modulus below 2^96: a beat on start is
// taken when busy is low, and exactly one result beat follows on out_valid,
// held for a single cycle; the receiver cannot stall, so it must take the
// result in that cycle. Latency depends on the data. Each REDC runs on one
// shared 32 by 32 multiplier; three of them open every item that passes the
// input check and up to three close it with the default word width. The
// binary GCD alternates subtractions with the removal of factors of two, and
// a small modulus may add modular doublings. An input that fails the check is
// answered without running any REDC. The user must see that configuration is
// written only while busy is low; the block itself does not enforce it.
module montgomery_modular_inverse_96 #(
  parameter int unsigned WORD_BITS = mmi96_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mmi96_pkg::LOW_BITS-1:0]    in_value_low,
  input  logic [mmi96_pkg::HIGH_BITS-1:0]   in_value_high,
  output logic                              out_valid,
  output logic [mmi96_pkg::LOW_BITS-1:0]    out_inverse_low,
  output logic [mmi96_pkg::HIGH_BITS-1:0]   out_inverse_high,
  output logic                              out_invertible,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [mmi96_pkg::LOW_BITS-1:0]    cfg_data
);
  import mmi96_pkg::*;

  logic [LOW_BITS-1:0]  mod_low_r;
  logic [HIGH_BITS-1:0] mod_high_r;
  logic [LOW_BITS-1:0]  neg_inv_r;
  cmd_t                 cmd;
  sts_t                 sts;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_low_r  <= MOD_LOW_RST;
      mod_high_r <= MOD_HIGH_RST;
      neg_inv_r  <= NEG_INV_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOD_LOW:  mod_low_r  <= cfg_data;
        REG_MOD_HIGH: mod_high_r <= cfg_data[HIGH_BITS-1:0];
        REG_NEG_INV:  neg_inv_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mmi96_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  mmi96_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .value_low    (in_value_low),
    .value_high   (in_value_high),
    .mod_low      (mod_low_r),
    .mod_high     (mod_high_r),
    .neg_inv      (neg_inv_r),
    .inverse_low  (out_inverse_low),
    .inverse_high (out_inverse_high),
    .invertible   (out_invertible)
  );

  // An accepted beat always makes the block busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not start work");

  // A result beat is never repeated.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

  // A failed result carries a zero inverse.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invertible |-> out_inverse_low == '0 && out_inverse_high == '0)
    else $error("non-invertible result is not zero");

endmodule

// ===== rtl/core/mmi96_ctrl.sv =====
module mmi96_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output mmi96_pkg::cmd_t     cmd,
  input  mmi96_pkg::sts_t     sts
);
  import mmi96_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_RCLR  = 4'd2;
  localparam logic [3:0] S_RMUL  = 4'd3;
  localparam logic [3:0] S_RACC  = 4'd4;
  localparam logic [3:0] S_RKSET = 4'd5;
  localparam logic [3:0] S_RDONE = 4'd6;
  localparam logic [3:0] S_CZ    = 4'd7;
  localparam logic [3:0] S_NORM  = 4'd8;
  localparam logic [3:0] S_LOOP  = 4'd9;
  localparam logic [3:0] S_SHA   = 4'd10;
  localparam logic [3:0] S_SHB   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_TNEG  = 4'd13;
  localparam logic [3:0] S_TW    = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [1:0] rcnt_r, rcnt_nxt;
  logic       kph_r, kph_nxt;
  logic       i_r, i_nxt;
  logic [1:0] j_r, j_nxt;
  logic       use_u_r, use_u_nxt;
  logic       svar_r, svar_nxt;
  logic       strobe_r, strobe_nxt;
  logic [1:0] jmax;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = strobe_r;
  assign jmax      = kph_r ? 2'd1 : 2'd2;

  // Sequencer: next state and command for the datapath.
  always_comb begin
    state_nxt  = state_r;
    rcnt_nxt   = rcnt_r;
    kph_nxt    = kph_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    use_u_nxt  = use_u_r;
    svar_nxt   = svar_r;
    strobe_nxt = 1'b0;
    cmd.op     = OP_NOP;
    cmd.kph    = kph_r;
    cmd.use_u  = use_u_r;
    cmd.s_var  = svar_r;
    cmd.xi     = i_r;
    cmd.yj     = j_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!sts.m_odd || sts.a_zero || !sts.a_lt_m) begin
          cmd.op     = OP_FAIL;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          rcnt_nxt  = 2'd0;
          use_u_nxt = 1'b0;
          svar_nxt  = 1'b0;
          state_nxt = S_RCLR;
        end
      end
      S_RCLR: begin
        cmd.op    = OP_CLR;
        kph_nxt   = 1'b1;
        i_nxt     = 1'b0;
        j_nxt     = 2'd0;
        state_nxt = S_RMUL;
      end
      S_RMUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_RACC;
      end
      S_RACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_RMUL;
        if (j_r == jmax) begin
          j_nxt = 2'd0;
          if (i_r) begin
            state_nxt = kph_r ? S_RKSET : S_RDONE;
          end else begin
            i_nxt = 1'b1;
          end
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      S_RKSET: begin
        cmd.op    = OP_KSET;
        kph_nxt   = 1'b0;
        i_nxt     = 1'b0;
        j_nxt     = 2'd0;
        state_nxt = S_RMUL;
      end
      S_RDONE: begin
        cmd.op = OP_RDONE;
        if (use_u_r) begin
          state_nxt = S_TW;
        end else begin
          rcnt_nxt  = rcnt_r + 2'd1;
          state_nxt = (rcnt_r == 2'd2) ? S_CZ : S_RCLR;
        end
      end
      S_CZ: begin
        if (sts.a_zero) begin
          cmd.op     = OP_FAIL;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op    = OP_INIT;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (!sts.a_odd) begin
          cmd.op = OP_SHA;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.a_eq_b) begin
          state_nxt = S_FIN;
        end else if (sts.a_lt_b) begin
          cmd.op    = OP_SUBB;
          state_nxt = S_SHB;
        end else begin
          cmd.op    = OP_SUBA;
          state_nxt = S_SHA;
        end
      end
      S_SHA: begin
        if (!sts.a_odd) begin
          cmd.op = OP_SHA;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_SHB: begin
        if (!sts.b_odd) begin
          cmd.op = OP_SHB;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_FIN: begin
        if (!sts.a_one) begin
          cmd.op     = OP_FAIL;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_TNEG;
        end
      end
      S_TNEG: begin
        if (sts.t_neg) begin
          cmd.op = OP_DBL;
        end else begin
          state_nxt = S_TW;
        end
      end
      S_TW: begin
        use_u_nxt = 1'b1;
        if (sts.t_ge_w) begin
          svar_nxt  = 1'b0;
          state_nxt = S_RCLR;
        end else if (sts.t_pos) begin
          svar_nxt  = 1'b1;
          state_nxt = S_RCLR;
        end else begin
          cmd.op     = OP_OK;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rcnt_r   <= 2'd0;
      kph_r    <= 1'b0;
      i_r      <= 1'b0;
      j_r      <= 2'd0;
      use_u_r  <= 1'b0;
      svar_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rcnt_r   <= rcnt_nxt;
      kph_r    <= kph_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      use_u_r  <= use_u_nxt;
      svar_r   <= svar_nxt;
      strobe_r <= strobe_nxt;
    end
  end

endmodule

// ===== rtl/core/mmi96_dp.sv =====
module mmi96_dp #(
  parameter int unsigned WORD_BITS = mmi96_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  mmi96_pkg::cmd_t                   cmd,
  output mmi96_pkg::sts_t                   sts,
  input  logic [mmi96_pkg::LOW_BITS-1:0]    value_low,
  input  logic [mmi96_pkg::HIGH_BITS-1:0]   value_high,
  input  logic [mmi96_pkg::LOW_BITS-1:0]    mod_low,
  input  logic [mmi96_pkg::HIGH_BITS-1:0]   mod_high,
  input  logic [mmi96_pkg::LOW_BITS-1:0]    neg_inv,
  output logic [mmi96_pkg::LOW_BITS-1:0]    inverse_low,
  output logic [mmi96_pkg::HIGH_BITS-1:0]   inverse_high,
  output logic                              invertible
);
  import mmi96_pkg::*;

  logic [WIDE_BITS-1:0]        a_r, a_nxt, b_r, b_nxt, u_r, u_nxt, v_r, v_nxt;
  logic signed [T_BITS-1:0]    t_r, t_nxt;
  logic [ACC_BITS-1:0]         acc_r, acc_nxt;
  logic [2*LIMB_BITS-1:0]      pr_r, pr_nxt;
  logic [1:0]                  pos_r, pos_nxt;
  logic [LOW_BITS-1:0]         k_r, k_nxt;
  logic [MOD_BITS-1:0]         res_r, res_nxt;
  logic                        ok_r, ok_nxt;

  logic [WIDE_BITS-1:0]        m_w, tgt, dbl, redc;
  logic [LOW_BITS-1:0]         xop;
  logic [MOD_BITS-1:0]         yop;
  logic [LIMB_BITS-1:0]        xl, yl;
  logic [6:0]                  s;

  assign m_w = {32'd0, mod_high, mod_low};
  assign tgt = cmd.use_u ? u_r : a_r;

  // REDC shift: the word width, or the leftover count of powers of two.
  assign s = cmd.s_var ? t_r[6:0] : 7'(WORD_BITS);

  // Limb selection for the shared 32 by 32 multiplier.
  assign xop = cmd.kph ? tgt[LOW_BITS-1:0] : k_r;
  assign yop = cmd.kph ? {32'd0, neg_inv} : {mod_high, mod_low};
  assign xl  = cmd.xi ? xop[63:32] : xop[31:0];
  always_comb begin
    case (cmd.yj)
      2'd0:    yl = yop[31:0];
      2'd1:    yl = yop[63:32];
      default: yl = yop[95:64];
    endcase
  end

  assign redc = WIDE_BITS'(acc_r >> s);
  assign dbl  = ({u_r[WIDE_BITS-2:0], 1'b0} >= m_w) ?
                ({u_r[WIDE_BITS-2:0], 1'b0} - m_w) : {u_r[WIDE_BITS-2:0], 1'b0};

  // Status towards the controller.
  assign sts.m_odd  = mod_low[0];
  assign sts.a_zero = (a_r == '0);
  assign sts.a_lt_m = (a_r < m_w);
  assign sts.a_one  = (a_r == WIDE_BITS'(1));
  assign sts.a_eq_b = (a_r == b_r);
  assign sts.a_lt_b = (a_r < b_r);
  assign sts.a_odd  = a_r[0];
  assign sts.b_odd  = b_r[0];
  assign sts.t_neg  = t_r[T_BITS-1];
  assign sts.t_pos  = (t_r > 0);
  assign sts.t_ge_w = (t_r >= $signed(T_BITS'(WORD_BITS)));

  // Datapath operations.
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    u_nxt   = u_r;
    v_nxt   = v_r;
    t_nxt   = t_r;
    acc_nxt = acc_r;
    pr_nxt  = pr_r;
    pos_nxt = pos_r;
    k_nxt   = k_r;
    res_nxt = res_r;
    ok_nxt  = ok_r;
    case (cmd.op)
      OP_LOAD: begin
        a_nxt = {32'd0, value_high, value_low};
      end
      OP_CLR: begin
        acc_nxt = '0;
      end
      OP_MUL: begin
        pr_nxt  = (2*LIMB_BITS)'(xl) * (2*LIMB_BITS)'(yl);
        pos_nxt = 2'({1'b0, cmd.xi} + cmd.yj);
      end
      OP_ACC: begin
        acc_nxt = acc_r + (ACC_BITS'(pr_r) << {pos_r, 5'd0});
      end
      OP_KSET: begin
        k_nxt   = acc_r[LOW_BITS-1:0] & ~({LOW_BITS{1'b1}} << s);
        acc_nxt = {64'd0, tgt};
      end
      OP_RDONE: begin
        if (cmd.use_u) begin
          u_nxt = redc;
          t_nxt = cmd.s_var ? '0 : (t_r - $signed(T_BITS'(WORD_BITS)));
        end else begin
          a_nxt = redc;
        end
      end
      OP_INIT: begin
        b_nxt = m_w;
        u_nxt = WIDE_BITS'(1);
        v_nxt = '0;
        t_nxt = -$signed(T_BITS'(WORD_BITS));
      end
      OP_SHA: begin
        a_nxt = a_r >> 1;
        v_nxt = v_r << 1;
        t_nxt = t_r + $signed(T_BITS'(1));
      end
      OP_SHB: begin
        b_nxt = b_r >> 1;
        u_nxt = u_r << 1;
        t_nxt = t_r + $signed(T_BITS'(1));
      end
      OP_SUBA: begin
        a_nxt = a_r - b_r;
        u_nxt = u_r + v_r;
      end
      OP_SUBB: begin
        b_nxt = b_r - a_r;
        v_nxt = v_r + u_r;
      end
      OP_DBL: begin
        u_nxt = dbl;
        t_nxt = t_r + $signed(T_BITS'(1));
      end
      OP_OK: begin
        res_nxt = u_r[MOD_BITS-1:0];
        ok_nxt  = 1'b1;
      end
      OP_FAIL: begin
        res_nxt = '0;
        ok_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    t_r   <= t_nxt;
    acc_r <= acc_nxt;
    pr_r  <= pr_nxt;
    pos_r <= pos_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
    ok_r  <= ok_nxt;
  end

  assign inverse_low  = res_r[LOW_BITS-1:0];
  assign inverse_high = res_r[MOD_BITS-1:LOW_BITS];
  assign invertible   = ok_r;

endmodule
